// ===== rtl/core/lsra_pkg.sv =====
// Shared types and constants for the linear scan register allocator.
// Holds the controller states, command and status words, outcome codes
// and configuration register indexes; no dependencies.
package lsra_pkg;

  // Register file size, fixed by the 4-bit register index
  localparam int NUM_REG_SLOTS = 16;
  localparam int REG_IDX_W     = 4;

  // Length term of the interval value is (end - start) / 4
  localparam int LEN_SHIFT = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_WEIGHT_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_RESTORE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REPEAT_USES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_CROSS_WT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CALLER_MAX_WT   = 3'd4;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_LOOP_WEIGHT_THR = 16'd30;
  localparam logic [15:0] RST_SAVE_RESTORE    = 16'd2;
  localparam logic [7:0]  RST_MIN_REPEAT_USES = 8'd2;
  localparam logic [7:0]  RST_CALL_CROSS_WT   = 8'd25;
  localparam logic [15:0] RST_CALLER_MAX_WT   = 16'd5;

  typedef struct packed {
    logic [15:0] loop_weight_threshold;
    logic [15:0] save_restore_cost;
    logic [7:0]  min_repeat_uses;
    logic [7:0]  call_crossing_weight;
    logic [15:0] caller_max_weight;
  } cfg_t;

  typedef enum logic [2:0] {
    OUT_FILTERED        = 3'd0,
    OUT_FREE_REG        = 3'd1,
    OUT_SPILL_NO_CALLEE = 3'd2,
    OUT_SPILL_LOST      = 3'd3,
    OUT_EVICT           = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_EXPIRE,
    S_PICK,
    S_VICTIM,
    S_DECIDE,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic idx_clr;
    logic expire;
    logic pick;
    logic victim;
    logic decide;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic profitable;
    logic idx_last;
    logic pick_found;
    logic any_free;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/lsra_cfg.sv =====
// Configuration register bank of the linear scan register allocator.
// Depends on lsra_pkg for register indexes, reset values and cfg_t.
module lsra_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lsra_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lsra_pkg::cfg_t                 cfg_o
);
  import lsra_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always take a word; writes must happen only while the block is idle, and the block does not enforce it
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOOP_WEIGHT_THR: cfg_d.loop_weight_threshold = cfg_data_i;
        CFG_SAVE_RESTORE:    cfg_d.save_restore_cost     = cfg_data_i;
        CFG_MIN_REPEAT_USES: cfg_d.min_repeat_uses       = cfg_data_i[7:0];
        CFG_CALL_CROSS_WT:   cfg_d.call_crossing_weight  = cfg_data_i[7:0];
        CFG_CALLER_MAX_WT:   cfg_d.caller_max_weight     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_weight_threshold <= RST_LOOP_WEIGHT_THR;
      cfg_q.save_restore_cost     <= RST_SAVE_RESTORE;
      cfg_q.min_repeat_uses       <= RST_MIN_REPEAT_USES;
      cfg_q.call_crossing_weight  <= RST_CALL_CROSS_WT;
      cfg_q.caller_max_weight     <= RST_CALLER_MAX_WT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/lsra_ctrl.sv =====
// Sequencing controller of the linear scan register allocator.
// Depends on lsra_pkg for state_e, cmd_t and status_t.
module lsra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsra_pkg::status_t status_i,
  output lsra_pkg::cmd_t    cmd_o
);
  import lsra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum     = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = status_i.profitable ? S_EXPIRE : S_DONE;
      end
      S_EXPIRE: begin
        cmd_o.expire = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        if (status_i.pick_found || status_i.any_free) begin
          state_d = S_DONE;
        end else begin
          state_d = S_VICTIM;
        end
      end
      S_VICTIM: begin
        cmd_o.victim = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/lsra_dp.sv =====
// Datapath of the linear scan register allocator: input latch, interval
// value, busy mask, holder store, scan index, victim tracking and output
// register. Depends on lsra_pkg for cfg_t, cmd_t, status_t and outcomes.
module lsra_dp #(
  parameter int CALLER_REGS = 5,
  parameter int CALLEE_REGS = 11,
  parameter int POS_BITS    = 16,
  parameter int VREG_BITS   = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsra_pkg::cfg_t       cfg_i,
  input  lsra_pkg::cmd_t       cmd_i,
  output lsra_pkg::status_t    status_o,
  input  logic                 new_function_i,
  input  logic [VREG_BITS-1:0] vreg_id_i,
  input  logic [POS_BITS-1:0]  start_pos_i,
  input  logic [POS_BITS-1:0]  end_pos_i,
  input  logic [15:0]          spill_weight_i,
  input  logic [7:0]           use_count_i,
  input  logic [7:0]           call_crossings_i,
  input  logic                 loop_carried_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VREG_BITS-1:0] out_vreg_id_o,
  output logic [2:0]           outcome_o,
  output logic [3:0]           reg_index_o,
  output logic                 evicted_valid_o,
  output logic [VREG_BITS-1:0] evicted_vreg_o
);
  import lsra_pkg::*;

  localparam int NREGS_RAW = CALLER_REGS + CALLEE_REGS;
  localparam int NREGS     = (NREGS_RAW > NUM_REG_SLOTS) ? NUM_REG_SLOTS : NREGS_RAW;
  localparam int LEN_W     = POS_BITS - LEN_SHIFT;
  localparam int COST_W    = (POS_BITS - 1 > 18) ? POS_BITS - 1 : 18;
  localparam logic [REG_IDX_W-1:0] LAST_IDX = REG_IDX_W'(NREGS - 1);

  // True when holder a is worth less than holder b
  function automatic logic less_valuable(
    input logic signed [COST_W-1:0] ca, input logic [POS_BITS-1:0] ea,
    input logic [VREG_BITS-1:0] va,
    input logic signed [COST_W-1:0] cb, input logic [POS_BITS-1:0] eb,
    input logic [VREG_BITS-1:0] vb
  );
    logic res;
    if (ca != cb) begin
      res = (ca < cb);
    end else if (ea != eb) begin
      res = (ea > eb);
    end else begin
      res = (va > vb);
    end
    return res;
  endfunction

  // Latched word
  logic [VREG_BITS-1:0] vreg_q;
  logic [POS_BITS-1:0]  start_q, end_q;
  logic [15:0]          weight_q;
  logic [7:0]           uses_q, cross_q;
  logic                 loop_q;

  // Interval value pieces
  logic [15:0]              prod_q;
  logic [LEN_W-1:0]         len_q;
  logic                     profit_q, need_callee_q;
  logic signed [COST_W-1:0] cost_q;

  // Allocation state
  logic [NUM_REG_SLOTS-1:0] busy_q, busy_d;
  logic [POS_BITS-1:0]      holder_end_q  [NUM_REG_SLOTS];
  logic [COST_W-1:0]        holder_cost_q [NUM_REG_SLOTS];
  logic [VREG_BITS-1:0]     holder_vreg_q [NUM_REG_SLOTS];
  logic [REG_IDX_W-1:0]     idx_q;

  // Victim tracking
  logic signed [COST_W-1:0] best_cost_q;
  logic [POS_BITS-1:0]      best_end_q;
  logic [VREG_BITS-1:0]     best_vreg_q;
  logic [REG_IDX_W-1:0]     best_idx_q;

  // Pending result and output register
  outcome_e             res_outcome_q;
  logic [3:0]           res_reg_q;
  logic                 res_ev_valid_q;
  logic [VREG_BITS-1:0] res_ev_vreg_q;
  logic                 out_valid_q;
  logic [VREG_BITS-1:0] out_vreg_q, out_ev_vreg_q;
  logic [2:0]           out_outcome_q;
  logic [3:0]           out_reg_q;
  logic                 out_ev_valid_q;

  // Combinational helpers
  logic                     callee_ok, caller_ok;
  logic [POS_BITS-1:0]      diff;
  logic [COST_W-1:0]        cost_sum;
  logic [NUM_REG_SLOTS-1:0] region, free_pick, free_all;
  logic [REG_IDX_W-1:0]     pick_idx;
  logic                     pick_found;
  logic signed [COST_W-1:0] rd_cost;
  logic                     victim_take, evict_win;
  logic                     hold_we;
  logic [REG_IDX_W-1:0]     hold_waddr;

  // Profitability of the latched interval
  always_comb begin
    callee_ok = (uses_q != 8'd0) &&
                ((cross_q != 8'd0) ||
                 (weight_q >= cfg_i.loop_weight_threshold) ||
                 ((weight_q > cfg_i.save_restore_cost) &&
                  (uses_q >= cfg_i.min_repeat_uses)));
    caller_ok = (uses_q != 8'd0) && (weight_q <= cfg_i.caller_max_weight) &&
                (cross_q == 8'd0) && !loop_q;
  end

  assign diff     = end_q - start_q;
  assign cost_sum = COST_W'(weight_q) + COST_W'(prod_q) - COST_W'(len_q);

  // Candidate masks and lowest free register
  always_comb begin
    for (int r = 0; r < NUM_REG_SLOTS; r++) begin
      region[r] = (r < NREGS) && (!need_callee_q || (r >= CALLER_REGS));
      free_all[r] = (r < NREGS) && !busy_q[r];
    end
    free_pick  = free_all & region;
    pick_found = |free_pick;
    pick_idx   = '0;
    for (int r = NUM_REG_SLOTS - 1; r >= 0; r--) begin
      if (free_pick[r]) begin
        pick_idx = REG_IDX_W'(r);
      end
    end
  end

  assign rd_cost     = $signed(holder_cost_q[idx_q]);
  assign victim_take = (idx_q == '0) ||
                       less_valuable(rd_cost, holder_end_q[idx_q], holder_vreg_q[idx_q],
                                     best_cost_q, best_end_q, best_vreg_q);
  assign evict_win   = less_valuable(best_cost_q, best_end_q, best_vreg_q,
                                     cost_q, end_q, vreg_q);

  // Holder write port
  always_comb begin
    hold_we    = 1'b0;
    hold_waddr = pick_idx;
    if (cmd_i.pick && pick_found) begin
      hold_we = 1'b1;
    end else if (cmd_i.decide && evict_win) begin
      hold_we    = 1'b1;
      hold_waddr = best_idx_q;
    end
  end

  // Busy mask: clear on new function, drop expired, set on allocation
  always_comb begin
    busy_d = busy_q;
    if (cmd_i.load && new_function_i) begin
      busy_d = '0;
    end
    if (cmd_i.expire && busy_q[idx_q] && (holder_end_q[idx_q] < start_q)) begin
      busy_d[idx_q] = 1'b0;
    end
    if (hold_we) begin
      busy_d[hold_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Holder store, written on allocation only
  always_ff @(posedge clk_i) begin
    if (hold_we) begin
      holder_end_q[hold_waddr]  <= end_q;
      holder_cost_q[hold_waddr] <= cost_q;
      holder_vreg_q[hold_waddr] <= vreg_q;
    end
  end

  // Scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.expire || cmd_i.victim) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Input latch, value computation, victim tracking and pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vreg_q         <= vreg_id_i;
      start_q        <= start_pos_i;
      end_q          <= end_pos_i;
      weight_q       <= spill_weight_i;
      uses_q         <= use_count_i;
      cross_q        <= call_crossings_i;
      loop_q         <= loop_carried_i;
      res_outcome_q  <= OUT_FILTERED;
      res_reg_q      <= '0;
      res_ev_valid_q <= 1'b0;
      res_ev_vreg_q  <= '0;
    end
    if (cmd_i.mul) begin
      prod_q        <= 16'(cross_q) * 16'(cfg_i.call_crossing_weight);
      len_q         <= (end_q > start_q) ? diff[POS_BITS-1:LEN_SHIFT] : '0;
      profit_q      <= callee_ok || caller_ok;
      need_callee_q <= (cross_q != 8'd0) || loop_q;
    end
    if (cmd_i.sum) begin
      cost_q <= $signed(cost_sum);
    end
    if (cmd_i.pick) begin
      if (pick_found) begin
        res_outcome_q <= OUT_FREE_REG;
        res_reg_q     <= 4'(pick_idx);
      end else begin
        res_outcome_q <= OUT_SPILL_NO_CALLEE;
      end
    end
    if (cmd_i.victim && victim_take) begin
      best_cost_q <= rd_cost;
      best_end_q  <= holder_end_q[idx_q];
      best_vreg_q <= holder_vreg_q[idx_q];
      best_idx_q  <= idx_q;
    end
    if (cmd_i.decide) begin
      if (evict_win) begin
        res_outcome_q  <= OUT_EVICT;
        res_reg_q      <= 4'(best_idx_q);
        res_ev_valid_q <= 1'b1;
        res_ev_vreg_q  <= best_vreg_q;
      end else begin
        res_outcome_q <= OUT_SPILL_LOST;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_vreg_q     <= vreg_q;
      out_outcome_q  <= res_outcome_q;
      out_reg_q      <= res_reg_q;
      out_ev_valid_q <= res_ev_valid_q;
      out_ev_vreg_q  <= res_ev_vreg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_vreg_id_o   = out_vreg_q;
  assign outcome_o       = out_outcome_q;
  assign reg_index_o     = out_reg_q;
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_vreg_o  = out_ev_vreg_q;

  // Status back to the controller
  assign status_o.profitable = profit_q;
  assign status_o.idx_last   = (idx_q == LAST_IDX);
  assign status_o.pick_found = pick_found;
  assign status_o.any_free   = |free_all;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/core/linear_scan_register_allocator_top.sv =====
// Top level of the linear scan register allocator.
// Depends on lsra_pkg, lsra_cfg, lsra_ctrl and lsra_dp.
//
// Usage:
//   Live intervals enter on the input channel (in_valid_i / in_stall_o),
//   sorted by start, end and id; new_function_i frees every register first.
//   Each word yields exactly one result word on the output channel
//   (out_valid_o / out_stall_i): outcome, register given and any evicted
//   holder. Configuration words go in through cfg_valid_i / cfg_ready_o
//   with a register index and data, only while the block is idle.
//   After accept, the interval value is built in a product and a sum step;
//   a filtered interval then goes to the result. Others make one pass over
//   the holders to expire and pick a free register; when none is free, a
//   second pass picks the victim before the evict or spill decision, each
//   pass reading one holder per cycle.
//   One interval is in work at a time; the next is accepted from the cycle
//   after its result has moved to the output register, even if that one is
//   stalled. A stalled result holds on the output until taken.
//   Reset frees all registers, clears the output and loads the default
//   configuration; no clearing pass is needed.
module linear_scan_register_allocator_top #(
  parameter int CALLER_REGS = 5,
  parameter int CALLEE_REGS = 11,
  parameter int POS_BITS    = 16,
  parameter int VREG_BITS   = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            new_function_i,
  input  logic [VREG_BITS-1:0]            vreg_id_i,
  input  logic [POS_BITS-1:0]             start_pos_i,
  input  logic [POS_BITS-1:0]             end_pos_i,
  input  logic [15:0]                     spill_weight_i,
  input  logic [7:0]                      use_count_i,
  input  logic [7:0]                      call_crossings_i,
  input  logic                            loop_carried_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [VREG_BITS-1:0]            out_vreg_id_o,
  output logic [2:0]                      outcome_o,
  output logic [3:0]                      reg_index_o,
  output logic                            evicted_valid_o,
  output logic [VREG_BITS-1:0]            evicted_vreg_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lsra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lsra_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lsra_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lsra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsra_dp #(
    .CALLER_REGS (CALLER_REGS),
    .CALLEE_REGS (CALLEE_REGS),
    .POS_BITS    (POS_BITS),
    .VREG_BITS   (VREG_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .new_function_i   (new_function_i),
    .vreg_id_i        (vreg_id_i),
    .start_pos_i      (start_pos_i),
    .end_pos_i        (end_pos_i),
    .spill_weight_i   (spill_weight_i),
    .use_count_i      (use_count_i),
    .call_crossings_i (call_crossings_i),
    .loop_carried_i   (loop_carried_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_vreg_id_o    (out_vreg_id_o),
    .outcome_o        (outcome_o),
    .reg_index_o      (reg_index_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_vreg_o   (evicted_vreg_o)
  );

endmodule

// ===== verif/linear_scan_register_allocator_top_tb.sv =====
// Self-checking testbench for linear_scan_register_allocator_top.
// Depends on lsra_pkg and the allocator RTL. Drives a directed table, then random
// functions of live intervals under several settings, and scores every result word.
module linear_scan_register_allocator_top_tb;
  import lsra_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int CALLER_REGS     = 5;
  localparam int CALLEE_REGS     = 11;
  localparam int POS_W           = 16;
  localparam int VREG_W          = 12;
  localparam int NREGS           = (CALLER_REGS + CALLEE_REGS > 16) ? 16
                                   : CALLER_REGS + CALLEE_REGS;
  localparam int NUM_SETTINGS    = 5;
  localparam int WORDS_PER_SET   = 115;
  localparam int CHOKE_CYCLES    = 300;
  localparam int SETTLE_CYCLES   = 45;
  // Slowest run is near 600 words, each with the longest idle gap, a victim search and the longest stall.
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct {
    logic              new_function;
    logic [VREG_W-1:0] vreg;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  end_pos;
    logic [15:0]       weight;
    logic [7:0]        uses;
    logic [7:0]        calls;
    logic              loop_carried;
  } interval_t;

  typedef struct {
    logic [VREG_W-1:0] vreg;
    outcome_e          outcome;
    logic [3:0]        reg_idx;
    logic              ev_valid;
    logic [VREG_W-1:0] ev_vreg;
  } alloc_t;

  typedef struct {
    interval_t iv;
    bit        pinned;
    alloc_t    want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic new_function_i;
  logic [VREG_W-1:0] vreg_id_i;
  logic [POS_W-1:0] start_pos_i;
  logic [POS_W-1:0] end_pos_i;
  logic [15:0] spill_weight_i;
  logic [7:0] use_count_i;
  logic [7:0] call_crossings_i;
  logic loop_carried_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [VREG_W-1:0] out_vreg_id_o;
  logic [2:0] outcome_o;
  logic [3:0] reg_index_o;
  logic evicted_valid_o;
  logic [VREG_W-1:0] evicted_vreg_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Allocator mirror: settings and register tenants
  cfg_t              mirror;
  logic [15:0]       occupied;
  logic [POS_W-1:0]  tenant_end  [16];
  int                tenant_cost [16];
  logic [VREG_W-1:0] tenant_vreg [16];

  alloc_t      pending_results [$];
  script_row_t script [$];

  int  cycle_count = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  outcome_tally [5] = '{0, 0, 0, 0, 0};
  bit  rx_quiet = 1'b0;
  bit  tx_quiet = 1'b0;
  bit  choke_pending = 1'b0;

  // Random function generator state
  int                fn_left = 0;
  int                cur_start = 0;
  logic [VREG_W-1:0] next_vreg = '0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  linear_scan_register_allocator_top #(
    .CALLER_REGS (CALLER_REGS),
    .CALLEE_REGS (CALLEE_REGS),
    .POS_BITS    (POS_W),
    .VREG_BITS   (VREG_W)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .new_function_i   (new_function_i),
    .vreg_id_i        (vreg_id_i),
    .start_pos_i      (start_pos_i),
    .end_pos_i        (end_pos_i),
    .spill_weight_i   (spill_weight_i),
    .use_count_i      (use_count_i),
    .call_crossings_i (call_crossings_i),
    .loop_carried_i   (loop_carried_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_vreg_id_o    (out_vreg_id_o),
    .outcome_o        (outcome_o),
    .reg_index_o      (reg_index_o),
    .evicted_valid_o  (evicted_valid_o),
    .evicted_vreg_o   (evicted_vreg_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Allocation predictor
  // ---------------------------------------------------------------------------

  // True when tenant a is worth less than tenant b: cost, later end, larger id
  function automatic bit cheaper(int ca, logic [POS_W-1:0] ea, logic [VREG_W-1:0] va,
                                 int cb, logic [POS_W-1:0] eb, logic [VREG_W-1:0] vb);
    if (ca != cb) return ca < cb;
    if (ea != eb) return ea > eb;
    return va > vb;
  endfunction

  function automatic bit callee_worth(interval_t iv);
    if (iv.uses == 0) return 1'b0;
    if (iv.calls != 0) return 1'b1;
    if (iv.weight >= mirror.loop_weight_threshold) return 1'b1;
    if (iv.weight <= mirror.save_restore_cost) return 1'b0;
    return iv.uses >= mirror.min_repeat_uses;
  endfunction

  function automatic alloc_t allocate_interval(interval_t iv);
    alloc_t r;
    int     cost;
    int     pick;
    int     victim;
    bit     caller_ok;
    bit     wants_callee;
    r.vreg     = iv.vreg;
    r.outcome  = OUT_FILTERED;
    r.reg_idx  = '0;
    r.ev_valid = 1'b0;
    r.ev_vreg  = '0;
    if (iv.new_function) occupied = '0;

    cost = int'(iv.weight) + int'(iv.calls) * int'(mirror.call_crossing_weight);
    if (iv.end_pos > iv.start_pos) cost -= int'((iv.end_pos - iv.start_pos) >> LEN_SHIFT);

    // Drop intervals worth no register of either kind
    caller_ok = iv.uses != 0 && iv.weight <= mirror.caller_max_weight &&
                iv.calls == 0 && !iv.loop_carried;
    if (!callee_worth(iv) && !caller_ok) return r;
    wants_callee = (iv.calls != 0) || iv.loop_carried;

    // Free registers whose tenant ended before this start
    for (int i = 0; i < NREGS; i++)
      if (occupied[i] && tenant_end[i] < iv.start_pos) occupied[i] = 1'b0;

    pick = -1;
    for (int i = wants_callee ? CALLER_REGS : 0; i < NREGS; i++)
      if (!occupied[i] && pick < 0) pick = i;

    if (pick >= 0) begin
      r.outcome = OUT_FREE_REG;
    end else if (occupied[NREGS-1:0] != {NREGS{1'b1}}) begin
      r.outcome = OUT_SPILL_NO_CALLEE;
    end else begin
      // Find the least valuable tenant; the lowest register wins ties
      victim = 0;
      for (int i = 1; i < NREGS; i++)
        if (cheaper(tenant_cost[i], tenant_end[i], tenant_vreg[i],
                    tenant_cost[victim], tenant_end[victim], tenant_vreg[victim]))
          victim = i;
      if (cheaper(tenant_cost[victim], tenant_end[victim], tenant_vreg[victim],
                  cost, iv.end_pos, iv.vreg)) begin
        r.outcome  = OUT_EVICT;
        r.ev_valid = 1'b1;
        r.ev_vreg  = tenant_vreg[victim];
        pick       = victim;
      end else begin
        r.outcome = OUT_SPILL_LOST;
      end
    end

    if (pick >= 0) begin
      r.reg_idx         = 4'(pick);
      occupied[pick]    = 1'b1;
      tenant_end[pick]  = iv.end_pos;
      tenant_cost[pick] = cost;
      tenant_vreg[pick] = iv.vreg;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short idles, some medium, a few long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic interval_t mk(int nf, int vreg, int s, int e, int w, int u, int c,
                                   int lc);
    interval_t iv;
    iv.new_function = 1'(nf);
    iv.vreg         = VREG_W'(vreg);
    iv.start_pos    = POS_W'(s);
    iv.end_pos      = POS_W'(e);
    iv.weight       = 16'(w);
    iv.uses         = 8'(u);
    iv.calls        = 8'(c);
    iv.loop_carried = 1'(lc);
    return iv;
  endfunction

  function automatic alloc_t res(outcome_e oc, int reg_idx, int evv, int evr);
    alloc_t a;
    a.vreg     = '0;
    a.outcome  = oc;
    a.reg_idx  = 4'(reg_idx);
    a.ev_valid = 1'(evv);
    a.ev_vreg  = VREG_W'(evr);
    return a;
  endfunction

  task automatic add_row(input interval_t iv);
    script_row_t row;
    row.iv     = iv;
    row.pinned = 1'b0;
    row.want   = res(OUT_FILTERED, 0, 0, 0);
    script     = {script, row};
  endtask

  task automatic add_pinned(input interval_t iv, input alloc_t want);
    script_row_t row;
    row.iv        = iv;
    row.pinned    = 1'b1;
    row.want      = want;
    row.want.vreg = iv.vreg;
    script        = {script, row};
  endtask

  // Draw one interval: mostly ordered functions, some noise words
  function automatic interval_t draw_interval();
    interval_t iv;
    int        len;
    int        stop;
    if ($urandom_range(0, 11) == 0) begin
      iv.new_function = 1'($urandom_range(0, 1));
      iv.vreg         = VREG_W'($urandom);
      iv.start_pos    = POS_W'($urandom);
      iv.end_pos      = POS_W'($urandom);
      iv.weight       = 16'($urandom);
      iv.uses         = 8'($urandom);
      iv.calls        = 8'($urandom);
      iv.loop_carried = 1'($urandom_range(0, 1));
      return iv;
    end
    iv.new_function = 1'b0;
    if (fn_left == 0) begin
      iv.new_function = 1'b1;
      fn_left   = $urandom_range(8, 60);
      cur_start = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 2000);
      next_vreg = VREG_W'($urandom);
    end
    fn_left--;
    cur_start += $urandom_range(0, 6);
    if (cur_start > 65535) cur_start = 65535;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: len = $urandom_range(0, 40);
      9:          len = $urandom_range(0, 65535);
      default:    len = $urandom_range(41, 1500);
    endcase
    stop = cur_start + len;
    if (stop > 65535) stop = 65535;
    iv.vreg      = next_vreg;
    next_vreg    = next_vreg + 1'b1;
    iv.start_pos = POS_W'(cur_start);
    iv.end_pos   = POS_W'(stop);
    case ($urandom_range(0, 3))
      0:       iv.weight = 16'($urandom_range(0, 8));
      1:       iv.weight = 16'($urandom_range(0, 64));
      2:       iv.weight = 16'($urandom_range(0, 1000));
      default: iv.weight = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       iv.uses = 8'd0;
      1:       iv.uses = 8'($urandom);
      default: iv.uses = 8'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: iv.calls = 8'd0;
      9:                iv.calls = 8'($urandom);
      default:          iv.calls = 8'($urandom_range(1, 3));
    endcase
    iv.loop_carried = ($urandom_range(0, 3) == 0);
    return iv;
  endfunction

  function automatic cfg_t setting_for(int phase);
    cfg_t c;
    case (phase)
      0: c = '0;
      1: c = '1;
      2: begin
        c.loop_weight_threshold = 16'($urandom_range(10, 60));
        c.save_restore_cost     = 16'($urandom_range(0, 10));
        c.min_repeat_uses       = 8'($urandom_range(0, 4));
        c.call_crossing_weight  = 8'($urandom_range(0, 40));
        c.caller_max_weight     = 16'($urandom_range(0, 20));
      end
      3: c = cfg_t'({$urandom, $urandom});
      default: c = '{RST_LOOP_WEIGHT_THR, RST_SAVE_RESTORE, RST_MIN_REPEAT_USES,
                     RST_CALL_CROSS_WT, RST_CALLER_MAX_WT};
    endcase
    return c;
  endfunction

  // Write all five registers back to back; junk goes in the unused upper byte
  task automatic write_config(input cfg_t c);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idxs [5];
    logic [7:0]            junk;
    junk = 8'($urandom);
    vals = '{c.loop_weight_threshold, c.save_restore_cost, {junk, c.min_repeat_uses},
             {~junk, c.call_crossing_weight}, c.caller_max_weight};
    idxs = '{CFG_LOOP_WEIGHT_THR, CFG_SAVE_RESTORE, CFG_MIN_REPEAT_USES,
             CFG_CALL_CROSS_WT, CFG_CALLER_MAX_WT};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    mirror = c;
  endtask

  // Offer one word after a random idle; predict at the accepting edge
  task automatic send_word(input interval_t iv, input bit pinned, input alloc_t want);
    int     gap;
    alloc_t model;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    new_function_i   <= iv.new_function;
    vreg_id_i        <= iv.vreg;
    start_pos_i      <= iv.start_pos;
    end_pos_i        <= iv.end_pos;
    spill_weight_i   <= iv.weight;
    use_count_i      <= iv.uses;
    call_crossings_i <= iv.calls;
    loop_carried_i   <= iv.loop_carried;
    do @(posedge clk_i); while (in_stall_o);
    model = allocate_interval(iv);
    pending_results = {pending_results, pinned ? want : model};
    words_sent++;
  endtask

  // Stop offering and hold until every expected word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result scoring
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    alloc_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (outcome_o <= 3'd4) outcome_tally[outcome_o]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result word for vreg %0d with nothing expected", out_vreg_id_o);
      end else begin
        want = pending_results.pop_front();
        check_field("out_vreg_id", want.vreg, out_vreg_id_o);
        check_field("outcome", want.outcome, outcome_o);
        check_field("reg_index", want.reg_idx, reg_index_o);
        check_field("evicted_valid", want.ev_valid, evicted_valid_o);
        check_field("evicted_vreg", want.ev_vreg, evicted_vreg_o);
      end
    end
  end

  // Receiver: random stalls, quiet stretches and one long hold-off on request
  initial begin : result_sink
    int hold;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (choke_pending) begin
        choke_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk_i);
      end else begin
        hold = rx_quiet ? 0 : idle_len();
        out_stall_i <= (hold != 0);
        repeat ((hold != 0) ? hold : 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d words outstanding", cycle_count,
             pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    new_function_i   <= 1'b0;
    vreg_id_i        <= '0;
    start_pos_i      <= '0;
    end_pos_i        <= '0;
    spill_weight_i   <= '0;
    use_count_i      <= '0;
    call_crossings_i <= '0;
    loop_carried_i   <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    mirror   = '{RST_LOOP_WEIGHT_THR, RST_SAVE_RESTORE, RST_MIN_REPEAT_USES,
                 RST_CALL_CROSS_WT, RST_CALLER_MAX_WT};
    occupied = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset settings
    // New function, no uses: dropped
    add_pinned(mk(1, 0, 0, 0, 0, 0, 0, 0), res(OUT_FILTERED, 0, 0, 0));
    // Heavy plain value: lowest register, caller-saved
    add_pinned(mk(0, 7, 0, 65535, 40000, 1, 0, 0), res(OUT_FREE_REG, 0, 0, 0));
    // Every field at its top: first callee-saved register
    add_pinned(mk(0, 4095, 1, 65535, 65535, 255, 255, 1), res(OUT_FREE_REG, 5, 0, 0));
    // Loop-carried light value and single-use middle band: dropped
    add_pinned(mk(0, 2, 2, 5, 1, 1, 0, 1), res(OUT_FILTERED, 0, 0, 0));
    add_pinned(mk(0, 3, 2, 5, 10, 1, 0, 0), res(OUT_FILTERED, 0, 0, 0));
    // Fill the rest of the callee-saved bank with identical tenants
    for (int i = 0; i < 10; i++) add_row(mk(0, 10, 2, 60000, 40000, 3, 1, 0));
    // Call crossing with only caller-saved registers left: spill
    add_pinned(mk(0, 30, 3, 100, 50, 1, 1, 0), res(OUT_SPILL_NO_CALLEE, 0, 0, 0));
    // Fill caller-saved registers with identical cheap tenants
    for (int i = 0; i < 4; i++) add_row(mk(0, 31, 4, 60000, 0, 1, 0, 0));
    // Call crossing evicts the lowest of the equal cheap tenants, a caller-saved one
    add_pinned(mk(0, 40, 5, 20, 50, 2, 2, 0), res(OUT_EVICT, 1, 1, 31));
    // Newcomer worth less than every tenant: spill
    add_pinned(mk(0, 41, 6, 65535, 0, 1, 0, 0), res(OUT_SPILL_LOST, 0, 0, 0));
    // End before start; the tenant of register 1 has expired
    add_pinned(mk(0, 42, 30, 25, 5, 1, 0, 0), res(OUT_FREE_REG, 1, 0, 0));
    // Start out of order
    add_row(mk(0, 43, 10, 12, 5, 1, 0, 0));
    // New function frees everything
    add_pinned(mk(1, 44, 0, 0, 0, 1, 0, 0), res(OUT_FREE_REG, 0, 0, 0));

    foreach (script[i]) send_word(script[i].iv, script[i].pinned, script[i].want);
    drain();

    // Random functions under each setting
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_config(setting_for(p));
      rx_quiet = (p == 2);
      tx_quiet = (p == 2);
      if (p == 0) choke_pending = 1'b1;
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        if (n == WORDS_PER_SET / 2) drain();
        send_word(draw_interval(), 1'b0, res(OUT_FILTERED, 0, 0, 0));
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d intervals (directed table, then random functions) over %0d settings.",
             words_sent, NUM_SETTINGS + 1);
    $display("Outcomes: dropped %0d, free %0d, no callee %0d, lost %0d, evicted %0d; %0d bad.",
             outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
             outcome_tally[4], mismatches);
    if (mismatches == 0 && results_seen == words_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== linear_scan_register_allocator_top.f =====
rtl/core/lsra_pkg.sv
rtl/core/lsra_cfg.sv
rtl/core/lsra_ctrl.sv
rtl/core/lsra_dp.sv
rtl/core/linear_scan_register_allocator_top.sv
verif/linear_scan_register_allocator_top_tb.sv
